// ----- src/mpm_pkg.sv -----
package mpm_pkg;

    // Command codes of an input transaction
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_END    = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_SCAN   = 2'd3;

    // Status codes of a result transaction
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_PHASE = 2'd2;

    localparam int          COUNT_W   = 16;
    localparam int          SYM_W     = 5;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Consumed marks are stored as text epochs; zero means never consumed
    localparam int         EPOCH_W    = 8;
    localparam logic [7:0] EPOCH_ONE  = 8'd1;
    localparam logic [7:0] EPOCH_LAST = 8'hFF;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_CLR   = 4'd1;
    localparam logic [3:0] OP_ECLR  = 4'd2;
    localparam logic [3:0] OP_DISP  = 4'd3;
    localparam logic [3:0] OP_INS   = 4'd4;
    localparam logic [3:0] OP_END   = 4'd5;
    localparam logic [3:0] OP_BINIT = 4'd6;
    localparam logic [3:0] OP_BRV   = 4'd7;
    localparam logic [3:0] OP_BRT   = 4'd8;
    localparam logic [3:0] OP_BW    = 4'd9;
    localparam logic [3:0] OP_BOL   = 4'd10;
    localparam logic [3:0] OP_BNEXT = 4'd11;
    localparam logic [3:0] OP_BPOP  = 4'd12;
    localparam logic [3:0] OP_SSTEP = 4'd13;
    localparam logic [3:0] OP_SWALK = 4'd14;
    localparam logic [3:0] OP_FIN   = 4'd15;

    typedef struct packed {
        logic [1:0]       command;
        logic [SYM_W-1:0] symbol;
        logic             first;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] match_total;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic       load;
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       bad;
        logic       first;
        logic       epoch_wrap;
        logic       g_zero;
        logic       clr_done;
        logic       eclr_done;
        logic       v_zero;
        logic       c_last;
        logic       q_more;
        logic       k_hit;
        logic       o_zero;
        logic       out_free;
    } t_dp_stat;

endpackage

// ----- src/mpm_ctrl.sv -----
module mpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mpm_pkg::t_dp_stat i_stat,
    output mpm_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_END   = 4'd4;
    localparam logic [3:0] S_BINIT = 4'd5;
    localparam logic [3:0] S_BRV   = 4'd6;
    localparam logic [3:0] S_BRT   = 4'd7;
    localparam logic [3:0] S_BW    = 4'd8;
    localparam logic [3:0] S_BOL   = 4'd9;
    localparam logic [3:0] S_BNEXT = 4'd10;
    localparam logic [3:0] S_BPOP  = 4'd11;
    localparam logic [3:0] S_ECLR  = 4'd12;
    localparam logic [3:0] S_SSTEP = 4'd13;
    localparam logic [3:0] S_SWALK = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] w_op;

    // Next state and operation
    always_comb begin
        n_state = r_state;
        w_op    = mpm_pkg::OP_NONE;
        unique case (r_state)
            S_CLR: begin
                w_op = mpm_pkg::OP_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                w_op = mpm_pkg::OP_DISP;
                if (i_stat.bad) begin
                    n_state = S_FIN;
                end else begin
                    unique case (i_stat.command)
                        mpm_pkg::CMD_INSERT: n_state = S_INS;
                        mpm_pkg::CMD_END:    n_state = S_END;
                        mpm_pkg::CMD_BUILD:  n_state = S_BINIT;
                        default: begin
                            n_state = (i_stat.first && i_stat.epoch_wrap) ? S_ECLR : S_SSTEP;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_op    = mpm_pkg::OP_INS;
                n_state = S_FIN;
            end
            S_END: begin
                w_op    = mpm_pkg::OP_END;
                n_state = S_FIN;
            end
            S_BINIT: begin
                w_op    = mpm_pkg::OP_BINIT;
                n_state = S_BRV;
            end
            S_BRV: begin
                w_op    = mpm_pkg::OP_BRV;
                n_state = S_BRT;
            end
            S_BRT: begin
                w_op    = mpm_pkg::OP_BRT;
                n_state = S_BW;
            end
            S_BW: begin
                w_op    = mpm_pkg::OP_BW;
                n_state = i_stat.v_zero ? S_BNEXT : S_BOL;
            end
            S_BOL: begin
                w_op    = mpm_pkg::OP_BOL;
                n_state = S_BNEXT;
            end
            S_BNEXT: begin
                w_op = mpm_pkg::OP_BNEXT;
                priority if (!i_stat.c_last) n_state = S_BRV;
                else if (i_stat.q_more)      n_state = S_BPOP;
                else                         n_state = S_FIN;
            end
            S_BPOP: begin
                w_op    = mpm_pkg::OP_BPOP;
                n_state = S_BRV;
            end
            S_ECLR: begin
                w_op = mpm_pkg::OP_ECLR;
                if (i_stat.eclr_done) n_state = S_SSTEP;
            end
            S_SSTEP: begin
                w_op    = mpm_pkg::OP_SSTEP;
                n_state = i_stat.g_zero ? S_FIN : S_SWALK;
            end
            S_SWALK: begin
                w_op = mpm_pkg::OP_SWALK;
                if (i_stat.k_hit || i_stat.o_zero) n_state = S_FIN;
            end
            default: begin
                w_op = mpm_pkg::OP_FIN;
                if (i_stat.out_free) n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd.op   = w_op;
    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;

endmodule

// ----- src/mpm_datapath.sv -----
module mpm_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpm_pkg::t_dp_cmd   i_cmd,
    input  mpm_pkg::t_in_item  i_in_item,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output mpm_pkg::t_out_item o_out_item,
    output mpm_pkg::t_dp_stat  o_stat
);

    localparam int GD = MAX_NODES * ALPHABET;
    localparam int GW = $clog2(GD);
    localparam int NW = $clog2(MAX_NODES);
    localparam int SW = $clog2(ALPHABET);
    localparam int CW = mpm_pkg::COUNT_W;
    localparam int EW = mpm_pkg::EPOCH_W;

    // Memories
    logic [NW-1:0] goto_mem  [GD];
    logic [NW-1:0] fail_mem  [MAX_NODES];
    logic [NW-1:0] olink_mem [MAX_NODES];
    logic [CW-1:0] endc_mem  [MAX_NODES];
    logic [EW-1:0] cons_mem  [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];

    // Registered read data
    logic [NW-1:0] r_g_rd;
    logic [NW-1:0] r_f_rd;
    logic [NW-1:0] r_o_rd;
    logic [CW-1:0] r_e_rd;
    logic [EW-1:0] r_k_rd;
    logic [NW-1:0] r_q_rd;

    // Working registers
    logic [1:0]       r_cmd;
    logic [4:0]       r_sym;
    logic             r_first;
    logic [NW-1:0]    r_node_cnt;
    logic [NW-1:0]    r_ins_cur;
    logic [NW-1:0]    r_scan_cur;
    logic [CW-1:0]    r_total;
    logic             r_built;
    logic [EW-1:0]    r_epoch;
    logic [GW-1:0]    r_clr;
    logic [NW-1:0]    r_x;
    logic [NW-1:0]    r_fx;
    logic             r_root;
    logic [SW-1:0]    r_c;
    logic [NW-1:0]    r_v;
    logic [NW-1:0]    r_t;
    logic [NW-1:0]    r_p;
    logic [NW-1:0]    r_head;
    logic [NW-1:0]    r_tail;
    logic [1:0]       r_status;
    logic             r_o_valid;
    mpm_pkg::t_out_item r_o_item;

    logic          w_sym_ok;
    logic          w_bad;
    logic [SW-1:0] w_sym_col;
    logic [NW-1:0] w_row;
    logic [SW-1:0] w_col;
    logic [GW-1:0] w_g_addr;
    logic          w_g_re;
    logic          w_g_we;
    logic [GW-1:0] w_g_waddr;
    logic [NW-1:0] w_g_wdata;
    logic [NW-1:0] w_t;
    logic [NW-1:0] w_naddr;
    logic          w_n_re;
    logic          w_clr_lo;
    logic          w_full;
    logic          w_out_free;
    logic [NW-1:0] w_new_node;
    logic [NW-1:0] w_olink_val;
    logic [CW:0]   w_sum;

    // Decode of the latched transaction
    assign w_sym_ok  = int'(r_sym) < ALPHABET;
    assign w_sym_col = SW'(int'(r_sym));
    always_comb begin
        unique case (r_cmd)
            mpm_pkg::CMD_INSERT: w_bad = r_built || !w_sym_ok;
            mpm_pkg::CMD_END:    w_bad = r_built;
            mpm_pkg::CMD_BUILD:  w_bad = r_built;
            default:             w_bad = !r_built || !w_sym_ok;
        endcase
    end

    assign w_t         = r_root ? '0 : r_g_rd;
    assign w_full      = (r_node_cnt == NW'(MAX_NODES - 1));
    assign w_new_node  = r_node_cnt + 1'b1;
    assign w_out_free  = !r_o_valid || !i_out_stall;
    assign w_clr_lo    = (r_clr < GW'(MAX_NODES));
    assign w_olink_val = (r_t == '0) ? '0 : ((r_e_rd != '0) ? r_t : r_o_rd);
    assign w_sum       = {1'b0, r_total} + {1'b0, r_e_rd};

    // Goto table row and column selection
    always_comb begin
        w_row = r_x;
        w_col = r_c;
        unique case (i_cmd.op)
            mpm_pkg::OP_DISP, mpm_pkg::OP_INS: begin
                w_col = w_sym_col;
                if (r_cmd == mpm_pkg::CMD_SCAN) begin
                    w_row = r_first ? '0 : r_scan_cur;
                end else begin
                    w_row = r_ins_cur;
                end
            end
            mpm_pkg::OP_BRT: w_row = r_fx;
            default: ;
        endcase
    end
    assign w_g_addr = GW'(w_row) * GW'(ALPHABET) + GW'(w_col);

    assign w_g_re = (i_cmd.op == mpm_pkg::OP_DISP) || (i_cmd.op == mpm_pkg::OP_BRV)
                 || (i_cmd.op == mpm_pkg::OP_BRT);

    // Goto table write port
    always_comb begin
        w_g_we    = 1'b0;
        w_g_waddr = w_g_addr;
        w_g_wdata = '0;
        unique case (i_cmd.op)
            mpm_pkg::OP_CLR: begin
                w_g_we    = 1'b1;
                w_g_waddr = r_clr;
            end
            mpm_pkg::OP_INS: begin
                w_g_we    = (r_g_rd == '0) && !w_full;
                w_g_wdata = w_new_node;
            end
            mpm_pkg::OP_BW: begin
                w_g_we    = (r_v == '0);
                w_g_wdata = w_t;
            end
            default: ;
        endcase
    end

    // Node store read address (end count, output link, consumed mark)
    always_comb begin
        w_naddr = r_ins_cur;
        w_n_re  = 1'b1;
        unique case (i_cmd.op)
            mpm_pkg::OP_DISP:  w_naddr = r_ins_cur;
            mpm_pkg::OP_BW:    w_naddr = w_t;
            mpm_pkg::OP_SSTEP: w_naddr = r_g_rd;
            mpm_pkg::OP_SWALK: w_naddr = r_o_rd;
            default:           w_n_re  = 1'b0;
        endcase
    end

    // Goto table
    always_ff @(posedge i_clk) begin
        if (w_g_we) goto_mem[w_g_waddr] <= w_g_wdata;
        if (w_g_re) r_g_rd <= goto_mem[w_g_addr];
    end

    // Failure links
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mpm_pkg::OP_BW && r_v != '0) fail_mem[r_v] <= w_t;
        if (i_cmd.op == mpm_pkg::OP_BPOP) r_f_rd <= fail_mem[r_q_rd];
    end

    // Output links
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mpm_pkg::OP_BOL) olink_mem[r_v] <= w_olink_val;
        if (w_n_re) r_o_rd <= olink_mem[w_naddr];
    end

    // Pattern end counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mpm_pkg::OP_CLR && w_clr_lo) begin
            endc_mem[r_clr[NW-1:0]] <= '0;
        end else if (i_cmd.op == mpm_pkg::OP_END) begin
            endc_mem[r_ins_cur] <= (r_e_rd == mpm_pkg::COUNT_MAX) ? r_e_rd : r_e_rd + 1'b1;
        end
        if (w_n_re) r_e_rd <= endc_mem[w_naddr];
    end

    // Consumed marks
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == mpm_pkg::OP_CLR || i_cmd.op == mpm_pkg::OP_ECLR) && w_clr_lo) begin
            cons_mem[r_clr[NW-1:0]] <= '0;
        end else if (i_cmd.op == mpm_pkg::OP_SWALK && r_k_rd != r_epoch) begin
            cons_mem[r_p] <= r_epoch;
        end
        if (w_n_re) r_k_rd <= cons_mem[w_naddr];
    end

    // Breadth-first queue
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mpm_pkg::OP_BOL) queue_mem[r_tail] <= r_v;
        if (i_cmd.op == mpm_pkg::OP_BNEXT) r_q_rd <= queue_mem[r_head];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_item.command;
            r_sym   <= i_in_item.symbol;
            r_first <= i_in_item.first;
        end
        unique case (i_cmd.op)
            mpm_pkg::OP_BINIT: begin
                r_x <= '0;
                r_c <= '0;
            end
            mpm_pkg::OP_BRV: r_fx <= r_root ? '0 : r_f_rd;
            mpm_pkg::OP_BRT: r_v <= r_g_rd;
            mpm_pkg::OP_BW:  r_t <= w_t;
            mpm_pkg::OP_BNEXT: begin
                r_c <= (r_c == SW'(ALPHABET - 1)) ? '0 : r_c + 1'b1;
            end
            mpm_pkg::OP_BPOP:  r_x <= r_q_rd;
            mpm_pkg::OP_SSTEP: r_p <= r_g_rd;
            mpm_pkg::OP_SWALK: r_p <= r_o_rd;
            default: ;
        endcase
        if (i_cmd.op == mpm_pkg::OP_FIN && w_out_free) begin
            r_o_item.match_total <= r_total;
            r_o_item.status      <= r_status;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= '0;
            r_ins_cur  <= '0;
            r_scan_cur <= '0;
            r_total    <= '0;
            r_built    <= 1'b0;
            r_epoch    <= mpm_pkg::EPOCH_ONE;
            r_clr      <= '0;
            r_root     <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_status   <= mpm_pkg::ST_OK;
            r_o_valid  <= 1'b0;
        end else begin
            // Result register: loaded when free, emptied when taken
            if (i_cmd.op == mpm_pkg::OP_FIN && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                mpm_pkg::OP_CLR: begin
                    r_clr <= (r_clr == GW'(GD - 1)) ? '0 : r_clr + 1'b1;
                end
                mpm_pkg::OP_ECLR: begin
                    r_clr <= (r_clr == GW'(MAX_NODES - 1)) ? '0 : r_clr + 1'b1;
                end
                mpm_pkg::OP_DISP: begin
                    r_status <= w_bad ? mpm_pkg::ST_PHASE : mpm_pkg::ST_OK;
                    if (!w_bad && r_cmd == mpm_pkg::CMD_SCAN && r_first) begin
                        r_total <= '0;
                        r_epoch <= (r_epoch == mpm_pkg::EPOCH_LAST) ? mpm_pkg::EPOCH_ONE
                                                                      : r_epoch + 1'b1;
                    end
                end
                mpm_pkg::OP_INS: begin
                    priority if (r_g_rd != '0) begin
                        r_ins_cur <= r_g_rd;
                    end else if (w_full) begin
                        r_status <= mpm_pkg::ST_FULL;
                    end else begin
                        r_node_cnt <= w_new_node;
                        r_ins_cur  <= w_new_node;
                    end
                end
                mpm_pkg::OP_END: r_ins_cur <= '0;
                mpm_pkg::OP_BINIT: begin
                    r_root <= 1'b1;
                    r_head <= '0;
                    r_tail <= '0;
                end
                mpm_pkg::OP_BOL: r_tail <= r_tail + 1'b1;
                mpm_pkg::OP_BNEXT: begin
                    if (r_c == SW'(ALPHABET - 1)) begin
                        if (r_head != r_tail) begin
                            r_head <= r_head + 1'b1;
                        end else begin
                            r_built <= 1'b1;
                        end
                    end
                end
                mpm_pkg::OP_BPOP:  r_root <= 1'b0;
                mpm_pkg::OP_SSTEP: r_scan_cur <= r_g_rd;
                mpm_pkg::OP_SWALK: begin
                    if (r_k_rd != r_epoch) begin
                        r_total <= w_sum[CW] ? mpm_pkg::COUNT_MAX : w_sum[CW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Status to the controller
    assign o_stat.command    = r_cmd;
    assign o_stat.bad        = w_bad;
    assign o_stat.first      = r_first;
    assign o_stat.epoch_wrap = (r_epoch == mpm_pkg::EPOCH_LAST);
    assign o_stat.g_zero     = (r_g_rd == '0);
    assign o_stat.clr_done   = (r_clr == GW'(GD - 1));
    assign o_stat.eclr_done  = (r_clr == GW'(MAX_NODES - 1));
    assign o_stat.v_zero     = (r_v == '0);
    assign o_stat.c_last     = (r_c == SW'(ALPHABET - 1));
    assign o_stat.q_more     = (r_head != r_tail);
    assign o_stat.k_hit      = (r_k_rd == r_epoch);
    assign o_stat.o_zero     = (r_o_rd == '0);
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

// ----- src/multi_pattern_matcher.sv -----
// Aho-Corasick multi-pattern matcher; one result transaction per input transaction.
// Insert and end pattern pass dispatch, their own step and the result; a scan landing on
// the root passes dispatch, scan step and result; a refused command goes to the result.
// A scan reaching a node walks the output-link chain up to the first consumed node or its
// end; a first scan when the 8-bit text epoch wraps sweeps the marks. 1 port on goto.
// Build per node and symbol: read, fail read, write; link step per child; pop per node.
// Reset (synchronous, active low) starts a clear of the goto table, end counts and marks.
module multi_pattern_matcher #(
    parameter int MAX_NODES = 1024,
    parameter int ALPHABET  = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mpm_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mpm_pkg::t_out_item o_out_item
);

    mpm_pkg::t_dp_cmd  w_cmd;
    mpm_pkg::t_dp_stat w_stat;

    // Sequencer
    mpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Tables and working registers
    mpm_datapath #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_stat      (w_stat)
    );

endmodule
